@@ rtl/gaussian_hotspot_thickness_macros.svh @@
// Assertion macros used by the checker.
`ifndef GAUSSIAN_HOTSPOT_THICKNESS_MACROS_SVH
`define GAUSSIAN_HOTSPOT_THICKNESS_MACROS_SVH

// Check that cond at one edge implies expr at the next edge.
`define GHT_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

// Check that cond implies expr at the same edge.
`define GHT_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("same-cycle check failed");

`endif

@@ rtl/ght_pkg.sv @@
package ght_pkg;

  // Item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Register indexes
  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_K     = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
  localparam logic [56:0] EXP_CUTOFF = 57'd12 << 36;

  // floor((2^32-1)/j) for the series divisors 1..10
  function automatic logic [31:0] recip(input logic [3:0] j);
    logic [31:0] r;
    unique case (j)
      4'd1:    r = 32'd4294967295;
      4'd2:    r = 32'd2147483647;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741823;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870911;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/gaussian_hotspot_thickness.sv @@
// Gaussian hotspot thickness engine.
// Input channel (in_valid/in_ready): a write beat (cmd 0) stores position
// (x_pos, y_pos) in table slot `slot`; slots at or above MAX_HOTSPOTS are
// dropped. A query beat (cmd 1) sums exp(-r^2*k) over the first
// hotspot_count table entries around point (x_pos, y_pos), scales the sum
// and returns one saturated thickness beat on the output channel.
// Configuration goes through the APB port: hotspot_count at 0x0,
// inv_two_width_sqr at 0x4, output_scale at 0x8.
// A write is stored in the table as it is accepted. A query walks the table
// through a single 32x32 multiplier and one memory read port: each entry
// is read and its exponent argument formed; an entry whose term falls below
// the exp cutoff goes straight to the accumulator, the others run the series
// and repeated squaring first. Accept, scale and output steps frame the walk.
// One item is in flight at a time.
// The result sits in an output register; a stalled receiver holds it, and
// the engine may accept and process the next item meanwhile, only waiting
// at its final step until the output register is free.
// Reset: registers take their defaults (count 0, k 0.5, scale 0) and the
// engine goes idle. Table contents stay undefined until written.
module gaussian_hotspot_thickness
  import ght_pkg::*;
#(
  parameter int MAX_HOTSPOTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_cmd,
  input  logic [9:0]         in_slot,
  input  logic signed [15:0] in_x_pos,
  input  logic signed [15:0] in_y_pos,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_thickness,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = (MAX_HOTSPOTS > 1) ? $clog2(MAX_HOTSPOTS) : 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RD    = 4'd1;
  localparam logic [3:0] ST_SQX   = 4'd2;
  localparam logic [3:0] ST_SQY   = 4'd3;
  localparam logic [3:0] ST_ADD   = 4'd4;
  localparam logic [3:0] ST_KMUL  = 4'd5;
  localparam logic [3:0] ST_GCALC = 4'd6;
  localparam logic [3:0] ST_EMUL  = 4'd7;
  localparam logic [3:0] ST_EREC  = 4'd8;
  localparam logic [3:0] ST_EDIV  = 4'd9;
  localparam logic [3:0] ST_SQ0   = 4'd10;
  localparam logic [3:0] ST_SQ    = 4'd11;
  localparam logic [3:0] ST_ACC   = 4'd12;
  localparam logic [3:0] ST_SCALE = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  // Configuration registers
  logic [10:0] count_r;
  logic [23:0] k_r;
  logic [23:0] scale_r;

  logic [3:0]  state_r;
  logic [10:0] n_r;
  logic [10:0] idx_r;
  logic [15:0] qx_r, qy_r;
  logic [32:0] r2_r;
  logic [29:0] g_r;
  logic [30:0] p_r;
  logic [29:0] q_r;
  logic [3:0]  j_r;
  logic [1:0]  sq_cnt_r;
  logic        zero_r;
  logic [26:0] sum_r;
  logic [63:0] mul_r;
  logic [31:0] rdata_r;
  logic        out_valid_r;
  logic [31:0] thickness_r;

  logic [31:0] mem [MAX_HOTSPOTS];

  logic        cfg_wr;
  logic        in_beat;
  logic [10:0] n_eff;
  logic [16:0] dx, dy;
  logic [15:0] adx, ady;
  logic [31:0] opa, opb;
  logic [56:0] a_val;
  logic [29:0] qt;
  logic [33:0] qtj;
  logic [33:0] rem;
  logic [29:0] quot;
  logic [16:0] e_term;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign out_valid     = out_valid_r;
  assign out_thickness = thickness_r;

  // Register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_COUNT: prdata = {21'd0, count_r};
      REG_K:     prdata = {8'd0, k_r};
      REG_SCALE: prdata = {8'd0, scale_r};
      default:   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 11'd0;
      k_r     <= 24'd32768;
      scale_r <= 24'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_COUNT: count_r <= pwdata[10:0];
        REG_K:     k_r     <= pwdata[23:0];
        REG_SCALE: scale_r <= pwdata[23:0];
        default:   ;
      endcase
    end
  end

  // Clamp the entry count to the table depth
  assign n_eff = (32'(count_r) > 32'(MAX_HOTSPOTS)) ? 11'(MAX_HOTSPOTS) : count_r;

  // Hotspot table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (in_beat && (in_cmd == CMD_WRITE) && (32'(in_slot) < 32'(MAX_HOTSPOTS))) begin
      mem[AW'(in_slot)] <= {in_y_pos, in_x_pos};
    end
    rdata_r <= mem[AW'(idx_r)];
  end

  // Distances from the query point to the current entry
  assign dx  = {qx_r[15], qx_r} - {rdata_r[15], rdata_r[15:0]};
  assign dy  = {qy_r[15], qy_r} - {rdata_r[31], rdata_r[31:16]};
  assign adx = dx[16] ? 16'(-dx) : dx[15:0];
  assign ady = dy[16] ? 16'(-dy) : dy[15:0];

  // Exponent argument, with the top bit of r^2 added as a shifted k
  assign a_val = 57'(mul_r[55:0]) + (r2_r[32] ? (57'(k_r) << 32) : 57'd0);

  // Divide by the series index: reciprocal estimate plus one correction
  assign qt     = mul_r[61:32];
  assign qtj    = 34'(qt) * 34'(j_r);
  assign rem    = 34'(q_r) - qtj;
  assign quot   = (rem >= 34'(j_r)) ? (qt + 30'd1) : qt;
  assign e_term = zero_r ? 17'd0 : 17'((32'(mul_r[60:30]) + 32'd8192) >> 14);

  // Shared multiplier operands; hold the scaled sum while the output waits
  always_comb begin
    opa = 32'd0;
    opb = 32'd0;
    unique case (state_r)
      ST_SQX:   begin opa = 32'(adx);          opb = 32'(adx);          end
      ST_SQY:   begin opa = 32'(ady);          opb = 32'(ady);          end
      ST_KMUL:  begin opa = r2_r[31:0];        opb = 32'(k_r);          end
      ST_EMUL:  begin opa = 32'(g_r);          opb = 32'(p_r);          end
      ST_EREC:  begin opa = 32'(mul_r[59:30]); opb = recip(j_r);        end
      ST_SQ0:   begin opa = 32'(p_r);          opb = 32'(p_r);          end
      ST_SQ:    begin opa = 32'(mul_r[60:30]); opb = 32'(mul_r[60:30]); end
      ST_SCALE, ST_OUT: begin opa = 32'(sum_r); opb = 32'(scale_r);     end
      default:  begin opa = 32'd0;             opb = 32'd0;             end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= 64'(opa) * 64'(opb);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= 11'd0;
    end else begin
      if (out_valid_r && out_ready && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_beat && (in_cmd == CMD_QUERY)) begin
            qx_r  <= in_x_pos;
            qy_r  <= in_y_pos;
            n_r   <= n_eff;
            idx_r <= 11'd0;
            sum_r <= 27'd0;
            state_r <= (n_eff == 11'd0) ? ST_SCALE : ST_RD;
          end
        end
        ST_RD:   state_r <= ST_SQX;
        ST_SQX:  state_r <= ST_SQY;
        ST_SQY: begin
          r2_r    <= {1'b0, mul_r[31:0]};
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          r2_r    <= r2_r + 33'(mul_r[31:0]);
          state_r <= ST_KMUL;
        end
        ST_KMUL: state_r <= ST_GCALC;
        ST_GCALC: begin
          // Drop terms past the cutoff straight to the accumulator
          if (a_val >= EXP_CUTOFF) begin
            zero_r  <= 1'b1;
            state_r <= ST_ACC;
          end else begin
            zero_r  <= 1'b0;
            g_r     <= a_val[39:10];
            p_r     <= Q30_ONE;
            j_r     <= 4'd10;
            state_r <= ST_EMUL;
          end
        end
        ST_EMUL: state_r <= ST_EREC;
        ST_EREC: begin
          q_r     <= mul_r[59:30];
          state_r <= ST_EDIV;
        end
        ST_EDIV: begin
          p_r <= Q30_ONE - 31'(quot);
          j_r <= j_r - 4'd1;
          state_r <= (j_r == 4'd1) ? ST_SQ0 : ST_EMUL;
        end
        ST_SQ0: begin
          sq_cnt_r <= 2'd0;
          state_r  <= ST_SQ;
        end
        ST_SQ: begin
          sq_cnt_r <= sq_cnt_r + 2'd1;
          if (sq_cnt_r == 2'd2) begin
            state_r <= ST_ACC;
          end
        end
        ST_ACC: begin
          sum_r <= sum_r + 27'(e_term);
          idx_r <= idx_r + 11'd1;
          state_r <= ((idx_r + 11'd1) == n_r) ? ST_SCALE : ST_RD;
        end
        ST_SCALE: state_r <= ST_OUT;
        ST_OUT: begin
          // Hold until the output register is free, then saturate
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            thickness_r <= (mul_r[63:48] != 16'd0) ? 32'hFFFF_FFFF : mul_r[47:16];
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/ght_checker.sv @@
`include "gaussian_hotspot_thickness_macros.svh"

module ght_checker
  import ght_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_thickness
);

  // Stalled result beat holds
  `GHT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `GHT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_thickness))

  // After a write the engine is ready again in the next cycle; a query keeps the engine busy
  `GHT_ASSERT_NEXT(a_write_one_cycle, in_valid && in_ready && (in_cmd == CMD_WRITE), in_ready)
  `GHT_ASSERT_NEXT(a_query_busy, in_valid && in_ready && (in_cmd == CMD_QUERY), !in_ready)

endmodule

bind gaussian_hotspot_thickness ght_checker u_ght_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import ght_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int FILL_SLOTS = 264;
  localparam int RANDOM_BEATS = 300;

  typedef enum logic {ROW_REG, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [1:0]         reg_idx;
    logic [31:0]        value;
    logic               cmd;
    logic [9:0]         slot;
    logic signed [15:0] x;
    logic signed [15:0] y;
    bit                 has_exp;
    logic [31:0]        exp_val;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_cmd;
  logic [9:0]         in_slot;
  logic signed [15:0] in_x_pos;
  logic signed [15:0] in_y_pos;
  logic               out_valid;
  logic               out_ready;
  logic [31:0]        out_thickness;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow of the block's state and registers
  logic [31:0] spot_mem [TABLE_DEPTH];
  logic [10:0] spot_count;
  logic [23:0] inv_k;
  logic [23:0] norm_scale;

  logic [31:0] thickness_q[$];
  row_t        rows[$];
  int          send_gap_pct;
  int          recv_stall_pct;
  int          errors;
  int          queries_sent;
  int          writes_sent;
  int          results_seen;

  gaussian_hotspot_thickness uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_slot      (in_slot),
    .in_x_pos     (in_x_pos),
    .in_y_pos     (in_y_pos),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_thickness(out_thickness),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // exp(-r2*k) in Q.16, series then repeated squaring
  function automatic logic [31:0] gauss_weight(input logic [63:0] r2, input logic [23:0] k);
    logic [63:0] a;
    logic [63:0] g;
    logic [63:0] p;
    a = r2 * {40'd0, k};
    if (a >= (64'd12 << 36)) return 32'd0;
    g = a >> 10;
    p = 64'd1 << 30;
    for (int j = 10; j >= 1; j--) p = (64'd1 << 30) - (((g * p) >> 30) / j);
    for (int j = 0; j < 4; j++) p = (p * p) >> 30;
    return 32'((p + (64'd1 << 13)) >> 14);
  endfunction

  function automatic logic [31:0] thickness_at(input logic signed [15:0] qx,
                                               input logic signed [15:0] qy);
    logic [63:0] sum;
    logic [63:0] prod;
    logic [63:0] r2;
    longint dx;
    longint dy;
    int n;
    sum = 0;
    n = (spot_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(spot_count);
    for (int i = 0; i < n; i++) begin
      dx = longint'(qx) - longint'($signed(spot_mem[i][15:0]));
      dy = longint'(qy) - longint'($signed(spot_mem[i][31:16]));
      r2 = 64'(dx * dx + dy * dy);
      sum += gauss_weight(r2, inv_k);
    end
    prod = (sum * {40'd0, norm_scale}) >> 16;
    return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
  endfunction

  function automatic row_t mk_reg(input logic [1:0] idx, input logic [31:0] value);
    row_t r;
    r = '{kind: ROW_REG, reg_idx: idx, value: value, cmd: CMD_WRITE, slot: '0,
          x: '0, y: '0, has_exp: 1'b0, exp_val: '0};
    return r;
  endfunction

  function automatic row_t mk_beat(input logic cmd, input logic [9:0] slot,
                                   input logic signed [15:0] x, input logic signed [15:0] y,
                                   input bit has_exp, input logic [31:0] exp_val);
    row_t r;
    r = '{kind: ROW_BEAT, reg_idx: '0, value: '0, cmd: cmd, slot: slot,
          x: x, y: y, has_exp: has_exp, exp_val: exp_val};
    return r;
  endfunction

  // Drain pending results, then write one register over APB
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    while (thickness_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_COUNT: spot_count = value[10:0];
      REG_K:     inv_k = value[23:0];
      REG_SCALE: norm_scale = value[23:0];
      default:   ;
    endcase
  endtask

  // Offer one beat, hold it until accepted, then update the shadow
  task automatic send_beat(input logic cmd, input logic [9:0] slot,
                           input logic signed [15:0] x, input logic signed [15:0] y,
                           input bit has_exp, input logic [31:0] exp_val);
    while ($urandom_range(0, 99) < send_gap_pct) @(negedge clk);
    in_valid = 1'b1;
    in_cmd = cmd;
    in_slot = slot;
    in_x_pos = x;
    in_y_pos = y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd == CMD_QUERY) begin
      thickness_q.push_back(has_exp ? exp_val : thickness_at(x, y));
      queries_sent++;
    end else begin
      spot_mem[slot] = {y, x};
      writes_sent++;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (thickness_q.size() == 0) begin
        $display("%0t: unexpected result beat, thickness %0d", $time, out_thickness);
        errors++;
      end else begin
        if (out_thickness !== thickness_q[0]) begin
          $display("%0t: thickness mismatch, expected %0d, actual %0d",
                   $time, thickness_q[0], out_thickness);
          errors++;
        end
        void'(thickness_q.pop_front());
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", thickness_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int n_cnt;
    int idx;
    logic [31:0] pick;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_WRITE;
    in_slot = '0;
    in_x_pos = '0;
    in_y_pos = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    errors = 0;
    queries_sent = 0;
    writes_sent = 0;
    results_seen = 0;
    send_gap_pct = 28;
    recv_stall_pct = 68;
    spot_count = '0;
    inv_k = 24'd32768;
    norm_scale = '0;
    foreach (spot_mem[i]) spot_mem[i] = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Count is zero after reset
    send_beat(CMD_QUERY, 10'd0, 16'sd0, 16'sd0, 1'b1, 32'd0);

    // Fill the low slots so no query can reach an unwritten entry
    for (int i = 0; i < FILL_SLOTS; i++) begin
      pick = $urandom;
      send_beat(CMD_WRITE, 10'(i), pick[15:0], pick[31:16], 1'b0, '0);
    end

    rows.push_back(mk_beat(CMD_WRITE, 10'd0, -16'sd32768, -16'sd32768, 1'b0, '0));
    rows.push_back(mk_beat(CMD_WRITE, 10'd1, 16'sd32767, 16'sd32767, 1'b0, '0));
    rows.push_back(mk_beat(CMD_WRITE, 10'd2, 16'sd0, 16'sd0, 1'b0, '0));
    rows.push_back(mk_beat(CMD_WRITE, 10'd3, 16'sd100, -16'sd100, 1'b0, '0));
    rows.push_back(mk_beat(CMD_WRITE, 10'd1023, 16'sd5, 16'sd5, 1'b0, '0));
    // Scale still zero: thickness is zero whatever the count
    rows.push_back(mk_reg(REG_COUNT, 32'd4));
    rows.push_back(mk_beat(CMD_QUERY, 10'd0, 16'sd0, 16'sd0, 1'b1, 32'd0));
    rows.push_back(mk_reg(REG_SCALE, 32'd65536));
    rows.push_back(mk_beat(CMD_QUERY, 10'd7, 16'sd0, 16'sd0, 1'b0, '0));
    rows.push_back(mk_beat(CMD_QUERY, 10'd0, -16'sd32768, -16'sd32768, 1'b0, '0));
    rows.push_back(mk_beat(CMD_QUERY, 10'd1023, 16'sd32767, 16'sd32767, 1'b0, '0));
    rows.push_back(mk_beat(CMD_QUERY, 10'd0, 16'sd100, -16'sd99, 1'b0, '0));
    // Zero k: every term is exactly one
    rows.push_back(mk_reg(REG_K, 32'd0));
    rows.push_back(mk_beat(CMD_QUERY, 10'd0, 16'sd1234, -16'sd4321, 1'b1, 32'd262144));
    rows.push_back(mk_reg(REG_SCALE, 32'hFF_FFFF));
    rows.push_back(mk_beat(CMD_QUERY, 10'd0, 16'sd0, 16'sd0, 1'b1, 32'd67108860));
    // Many full terms at full scale saturate the output
    rows.push_back(mk_reg(REG_COUNT, 32'(FILL_SLOTS)));
    rows.push_back(mk_beat(CMD_QUERY, 10'd0, 16'sd0, 16'sd0, 1'b1, 32'hFFFF_FFFF));
    rows.push_back(mk_reg(REG_K, 32'hFF_FFFF));
    rows.push_back(mk_beat(CMD_QUERY, 10'd0, 16'sd5, 16'sd5, 1'b0, '0));
    rows.push_back(mk_reg(REG_COUNT, 32'd0));
    rows.push_back(mk_beat(CMD_QUERY, 10'd0, 16'sd5, 16'sd5, 1'b1, 32'd0));

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) write_reg(rows[i].reg_idx, rows[i].value);
      else send_beat(rows[i].cmd, rows[i].slot, rows[i].x, rows[i].y,
                     rows[i].has_exp, rows[i].exp_val);
    end

    // Random part: queries mostly close to stored hotspots
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == RANDOM_BEATS / 3) begin
        send_gap_pct = 68;
        recv_stall_pct = 28;
      end else if (i == 2 * RANDOM_BEATS / 3) begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      if (i % 40 == 0) begin
        n_cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        write_reg(REG_COUNT, 32'(n_cnt));
        case ($urandom_range(0, 3))
          0:       pick = $urandom_range(0, 255);
          1:       pick = $urandom_range(256, 4095);
          2:       pick = $urandom & 32'hFF_FFFF;
          default: pick = 32'd32768;
        endcase
        write_reg(REG_K, pick);
        pick = ($urandom_range(0, 2) == 0) ? ($urandom & 32'hFF_FFFF) : 32'd65536;
        write_reg(REG_SCALE, pick);
      end
      pick = $urandom;
      if ($urandom_range(0, 99) < 30) begin
        send_beat(CMD_WRITE, 10'($urandom_range(0, 15)), pick[15:0], pick[31:16], 1'b0, '0);
      end else if ($urandom_range(0, 99) < 75) begin
        idx = (spot_count == 0) ? 0 : $urandom_range(0, int'(spot_count) - 1);
        send_beat(CMD_QUERY, pick[25:16],
                  16'(spot_mem[idx][15:0] + $urandom_range(0, 64) - 32),
                  16'(spot_mem[idx][31:16] + $urandom_range(0, 64) - 32), 1'b0, '0);
      end else begin
        send_beat(CMD_QUERY, pick[9:0], pick[15:0], pick[31:16], 1'b0, '0);
      end
    end

    while (thickness_q.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Covered %0d writes and %0d queries, %0d thickness beats checked,",
             writes_sent, queries_sent, results_seen);
    $display("across three idle patterns and extreme register settings.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
